// ----- sv/ils_pkg.sv -----
// Package for the indexed list store: list depth, field widths, op and status codes,
// and the request/response structs. No dependencies.
`default_nettype none
package ils_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 5;
  localparam int VAL_W = 32;

  localparam logic [2:0] OP_PREPEND = 3'd0;
  localparam logic [2:0] OP_APPEND  = 3'd1;
  localparam logic [2:0] OP_GET     = 3'd2;
  localparam logic [2:0] OP_SET     = 3'd3;
  localparam logic [2:0] OP_DELETE  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [VAL_W-1:0] NO_VALUE = '1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  typedef struct packed {
    logic [2:0]              op;
    logic [4:0]              index;
    logic signed [VAL_W-1:0] value_in;
  } list_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [1:0]              status;
    logic [CNT_W-1:0]        entry_count;
  } list_rsp_t;

endpackage
`default_nettype wire

// ----- sv/indexed_list_store_unit.sv -----
// Indexed list store: bounded ordered list with prepend, append, get, set and delete.
// Depends on ils_pkg (codes, depth, request/response structs).
//
//   channel   | handshake             | payload            | direction
//   ----------+-----------------------+--------------------+----------
//   request   | start / busy          | req  (list_req_t)  | in
//   response  | done (one-cycle pulse)| rsp  (list_rsp_t)  | out
//
// A request is taken on any edge with start high and busy low; busy is only
// high during reset, so one request can enter every cycle.
// A request passes the input register, then one pass of shift muxes over the
// entry registers that updates the list and loads the response register.
// Synchronous active-high reset empties the list (count to zero); entry
// contents are not cleared since no entry at or beyond count is ever returned.
// The receiver cannot stall: done is high for exactly one cycle per request.
`default_nettype none
module indexed_list_store_unit
  import ils_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire list_req_t req,
  output logic           done,
  output list_rsp_t      rsp
);

  // input register
  logic      s1_valid;
  list_req_t s1_req;

  // list state
  logic [VAL_W-1:0] entries      [DEPTH];
  logic [VAL_W-1:0] entries_next [DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  list_rsp_t rsp_next;
  logic      accept;
  logic      full;
  logic      in_range;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_req <= req;
    end
  end

  assign full     = (count >= FULL_COUNT);
  assign in_range = (s1_req.index < count);

  // next list contents: each entry picks from its own slot, a neighbour or
  // the incoming value
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_next[i] = entries[i];
    end
    count_next = count;
    rsp_next.read_value  = NO_VALUE;
    rsp_next.status      = ST_OK;

    if (s1_valid) begin
      case (s1_req.op)
        OP_PREPEND: begin
          if (full) begin
            rsp_next.status = ST_FULL;
          end else begin
            entries_next[0] = s1_req.value_in;
            for (int i = 1; i < DEPTH; i++) begin
              entries_next[i] = entries[i-1];
            end
            count_next = count + 1'b1;
          end
        end
        OP_APPEND: begin
          if (full) begin
            rsp_next.status = ST_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (CNT_W'(i) == count) begin
                entries_next[i] = s1_req.value_in;
              end
            end
            count_next = count + 1'b1;
          end
        end
        OP_GET: begin
          if (!in_range) begin
            rsp_next.status = ST_RANGE;
          end else begin
            rsp_next.read_value = entries[s1_req.index[IDX_W-1:0]];
          end
        end
        OP_SET: begin
          if (!in_range) begin
            rsp_next.status = ST_RANGE;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (5'(i) == s1_req.index) begin
                entries_next[i] = s1_req.value_in;
              end
            end
          end
        end
        OP_DELETE: begin
          if (!in_range) begin
            rsp_next.status = ST_RANGE;
          end else begin
            // close the gap: everything from the index onwards moves forward
            for (int i = 0; i < DEPTH - 1; i++) begin
              if (5'(i) >= s1_req.index) begin
                entries_next[i] = entries[i+1];
              end
            end
            count_next = count - 1'b1;
          end
        end
        default: begin
          // unused op codes: no change, status ok
        end
      endcase
    end
    rsp_next.entry_count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= s1_valid;
    end
    for (int i = 0; i < DEPTH; i++) begin
      entries[i] <= entries_next[i];
    end
    if (s1_valid) begin
      rsp <= rsp_next;
    end
  end

  // every accepted request is answered with done through the input and response registers
  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("request not answered after two cycles");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("response without a request");

  // reported count tracks the stored count and never exceeds the depth
  a_count : assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.entry_count == count) && (rsp.entry_count <= FULL_COUNT))
    else $error("entry count inconsistent");

  a_full : assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == ST_FULL)) |-> (rsp.entry_count == FULL_COUNT))
    else $error("full status with list not full");

endmodule
`default_nettype wire
